### hdl/owm_pkg.sv
// Package for the one-wire bus master: types, codes, constants and helper functions.
`timescale 1ns / 1ps

package owm_pkg;

  localparam int unsigned ScratchBytes = 9;
  localparam int unsigned AddressBytes = 8;

  localparam int unsigned WaitW = 10;

  localparam logic [WaitW-1:0] ResetLowUs   = 10'd500;
  localparam logic [WaitW-1:0] RecoverUs    = 10'd410;
  localparam logic [WaitW-1:0] TailOneUs    = 10'd60;
  localparam logic [WaitW-1:0] TailZeroUs   = 10'd10;
  localparam logic [WaitW-1:0] ReadTailUs   = 10'd55;
  localparam logic [WaitW-1:0] StuckLimitUs = 10'd250;

  localparam logic [7:0] CrcPoly      = 8'h8C;
  localparam logic [7:0] CmdMatchRom  = 8'h55;
  localparam logic [7:0] CmdSkipRom   = 8'hCC;
  localparam logic [7:0] CmdConvertT  = 8'h44;
  localparam logic [7:0] CmdReadPad   = 8'hBE;
  localparam logic [7:0] ResFieldMask = 8'h03;

  localparam logic [3:0] TxLenAddr  = 4'(AddressBytes + 2);
  localparam logic [3:0] TxLenShort = 4'd2;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_CONVERT = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  localparam logic [2:0] CFG_USE_ADDRESS   = 3'd0;
  localparam logic [2:0] CFG_ROM_ADDRESS   = 3'd1;
  localparam logic [2:0] CFG_PARASITE      = 3'd2;
  localparam logic [2:0] CFG_WRITE_ONE_LOW = 3'd3;
  localparam logic [2:0] CFG_WRITE_ZERO_LOW = 3'd4;
  localparam logic [2:0] CFG_READ_LOW      = 3'd5;
  localparam logic [2:0] CFG_READ_SAMPLE   = 3'd6;
  localparam logic [2:0] CFG_PRESENCE_DLY  = 3'd7;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_CONVERT    = 3'd1,
    ST_READ_OK    = 3'd2,
    ST_NO_PRESENT = 3'd3,
    ST_BUS_STUCK  = 3'd4,
    ST_ALL_SAME   = 3'd5,
    ST_CRC_ERROR  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_CONV  = 2'd1,
    KIND_FETCH = 2'd2
  } job_e;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_BUS_IDLE  = 10'b00_0000_0010,
    PH_RESET_LOW = 10'b00_0000_0100,
    PH_PRESENCE  = 10'b00_0000_1000,
    PH_RECOVER   = 10'b00_0001_0000,
    PH_WR_LOW    = 10'b00_0010_0000,
    PH_WR_TAIL   = 10'b00_0100_0000,
    PH_RD_LOW    = 10'b00_1000_0000,
    PH_RD_SAMPLE = 10'b01_0000_0000,
    PH_RD_TAIL   = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic        use_address;
    logic [63:0] rom_address;
    logic        parasite_power;
    logic [6:0]  write_one_low_us;
    logic [6:0]  write_zero_low_us;
    logic [6:0]  read_low_us;
    logic [6:0]  read_sample_us;
    logic [6:0]  presence_delay_us;
  } cfg_t;

  typedef struct packed {
    logic         drive_low;
    logic         strong_pullup;
    logic         busy;
    logic         accepted;
    logic         done;
    status_e      status;
    logic [15:0]  raw_temp;
    logic         temp_valid;
    logic [3:0]   resolution_bits;
    logic [9:0]   conversion_time_ms;
    logic         connected;
  } res_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = data;
    for (int j = 0; j < 8; j++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

  function automatic logic [9:0] conv_time(input logic [3:0] res);
    case (res)
      4'd9:    return 10'd100;
      4'd10:   return 10'd200;
      4'd11:   return 10'd400;
      default: return 10'd800;
    endcase
  endfunction

endpackage

### hdl/onewire_sensor_transfer_master_top.sv
// Top level of the one-wire bus master: input stage, result handshake and register port.
`timescale 1ns / 1ps

// Each input item is one microsecond tick of bus time carrying a request code
// and the sampled line level. A start request taken while idle begins a
// transfer; a request while busy counts as a plain tick. Every item yields
// exactly one result item with the bus drive, pullup and status after that tick.
// An item is held in an input register and then stepped through the sequencer
// into the state and result registers, where its result is offered. The block
// takes one item per cycle as long as results are taken; the rate is set by the
// single sequencer step per item. When the receiver stalls, the result stays on
// the output and one more item may be held in the input register; further items
// wait with ready low. Reset clears the transfer state, the reading and the flags,
// sets the resolution to twelve bits and loads the default slot timings.
// The configuration registers are written through the APB-style port; the user
// must write them only while the block is idle, which the block itself does not
// enforce; pready is always high.
module onewire_sensor_transfer_master_top
  import owm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic        line_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        drive_low_o,
  output logic        strong_pullup_o,
  output logic        busy_res_o,
  output logic        accepted_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic signed [15:0] raw_temp_o,
  output logic        temp_valid_o,
  output logic [3:0]  resolution_bits_o,
  output logic [9:0]  conversion_time_ms_o,
  output logic        connected_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_req_q;
  logic       s1_line_q;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       step;

  assign out_free    = !out_valid_q || out_ready_i;
  assign step        = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = out_free ? step : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q  <= req_type_i;
      s1_line_q <= line_high_i;
    end
  end

  owm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (s1_req_q),
    .line_i (s1_line_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o          = out_valid_q;
  assign drive_low_o          = res.drive_low;
  assign strong_pullup_o      = res.strong_pullup;
  assign busy_res_o           = res.busy;
  assign accepted_o           = res.accepted;
  assign done_res_o           = res.done;
  assign status_o             = res.status;
  assign raw_temp_o           = res.raw_temp;
  assign temp_valid_o         = res.temp_valid;
  assign resolution_bits_o    = res.resolution_bits;
  assign conversion_time_ms_o = res.conversion_time_ms;
  assign connected_o          = res.connected;

`ifndef NO_ASSERTIONS
  a_status_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == ST_NONE)
    else $error("status set on an item that ends no transfer");

  a_accept_starts_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> busy_res_o && !done_res_o && !strong_pullup_o)
    else $error("accepted start did not begin a transfer");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !drive_low_o)
    else $error("transfer ended while bus still busy");

  a_pullup_not_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strong_pullup_o |-> !drive_low_o)
    else $error("strong pullup and low drive at once");
`endif

endmodule

### hdl/owm_regs.sv
// Configuration register file of the one-wire bus master behind an APB-style port.
`timescale 1ns / 1ps

module owm_regs
  import owm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_address       <= 1'b0;
      cfg_q.rom_address       <= '0;
      cfg_q.parasite_power    <= 1'b0;
      cfg_q.write_one_low_us  <= 7'd5;
      cfg_q.write_zero_low_us <= 7'd59;
      cfg_q.read_low_us       <= 7'd3;
      cfg_q.read_sample_us    <= 7'd7;
      cfg_q.presence_delay_us <= 7'd69;
    end else if (wr_en) begin
      unique case (reg_idx)
        CFG_USE_ADDRESS:    cfg_q.use_address       <= pwdata[0];
        CFG_ROM_ADDRESS:    cfg_q.rom_address       <= pwdata;
        CFG_PARASITE:       cfg_q.parasite_power    <= pwdata[0];
        CFG_WRITE_ONE_LOW:  cfg_q.write_one_low_us  <= pwdata[6:0];
        CFG_WRITE_ZERO_LOW: cfg_q.write_zero_low_us <= pwdata[6:0];
        CFG_READ_LOW:       cfg_q.read_low_us       <= pwdata[6:0];
        CFG_READ_SAMPLE:    cfg_q.read_sample_us    <= pwdata[6:0];
        CFG_PRESENCE_DLY:   cfg_q.presence_delay_us <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      CFG_USE_ADDRESS:    prdata = {63'd0, cfg_q.use_address};
      CFG_ROM_ADDRESS:    prdata = cfg_q.rom_address;
      CFG_PARASITE:       prdata = {63'd0, cfg_q.parasite_power};
      CFG_WRITE_ONE_LOW:  prdata = {57'd0, cfg_q.write_one_low_us};
      CFG_WRITE_ZERO_LOW: prdata = {57'd0, cfg_q.write_zero_low_us};
      CFG_READ_LOW:       prdata = {57'd0, cfg_q.read_low_us};
      CFG_READ_SAMPLE:    prdata = {57'd0, cfg_q.read_sample_us};
      CFG_PRESENCE_DLY:   prdata = {57'd0, cfg_q.presence_delay_us};
      default:            prdata = '0;
    endcase
  end

endmodule

### hdl/owm_core.sv
// Bus sequencer of the one-wire master: transfer state, slot timing and scratchpad checks.
`timescale 1ns / 1ps

module owm_core
  import owm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] req_i,
  input  logic       line_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  phase_e            phase_q, phase_d;
  job_e              job_q, job_d;
  logic [WaitW-1:0]  wait_q, wait_d;
  logic [3:0]        tx_idx_q, tx_idx_d;
  logic [3:0]        rx_idx_q, rx_idx_d;
  logic [2:0]        bit_pos_q, bit_pos_d;
  logic [7:0]        shift_q, shift_d;
  logic [15:0]       raw_q, raw_d;
  logic [3:0]        res_bits_q, res_bits_d;
  logic              valid_q, valid_d;
  logic              conn_q, conn_d;
  logic              pullup_q, pullup_d;
  logic              acc_q, acc_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;

  // Digest of the scratchpad, built up one byte at a time as it arrives.
  logic [7:0]        byte0_q, byte1_q, byte4_q, crc_q;
  logic              same_q, crc_ok_q;
  logic              pad_wr;
  logic [7:0]        pad_byte;

  logic              over;
  logic [WaitW-1:0]  wait_dec;
  logic [WaitW-1:0]  wait_inc;
  logic [3:0]        tx_len;
  logic              last_bit;
  logic [7:0]        rx_byte;
  logic [2:0]        bit_pos_inc;
  logic [3:0]        new_res;
  logic [15:0]       raw_word;

  function automatic logic [7:0] tx_byte(input logic [3:0] i, input logic use_addr,
                                         input logic [63:0] rom, input job_e job);
    logic [7:0] cmd;
    logic [2:0] sel;
    cmd = (job == KIND_CONV) ? CmdConvertT : CmdReadPad;
    sel = 3'(i - 4'd1);
    if (i == 4'd0) begin
      return use_addr ? CmdMatchRom : CmdSkipRom;
    end
    if (use_addr && ({1'b0, i} <= 5'(AddressBytes))) begin
      return rom[{sel, 3'b000} +: 8];
    end
    return cmd;
  endfunction

  function automatic logic [WaitW-1:0] low_time(input logic b, input cfg_t cfg);
    return b ? {3'd0, cfg.write_one_low_us} : {3'd0, cfg.write_zero_low_us};
  endfunction

  assign over        = (wait_q <= 10'd1);
  assign wait_dec    = over ? '0 : wait_q - 10'd1;
  assign wait_inc    = wait_q + 10'd1;
  assign tx_len      = cfg_i.use_address ? TxLenAddr : TxLenShort;
  assign last_bit    = (bit_pos_q == 3'd7) && (({1'b0, tx_idx_q} + 5'd1) >= {1'b0, tx_len});
  assign bit_pos_inc = bit_pos_q + 3'd1;
  assign rx_byte     = shift_q | (8'(line_i) << bit_pos_q);
  assign new_res     = 4'((byte4_q >> 5) & ResFieldMask) + 4'd9;
  assign raw_word    = {byte1_q, byte0_q};

  always_comb begin
    phase_d    = phase_q;
    job_d      = job_q;
    wait_d     = wait_q;
    tx_idx_d   = tx_idx_q;
    rx_idx_d   = rx_idx_q;
    bit_pos_d  = bit_pos_q;
    shift_d    = shift_q;
    raw_d      = raw_q;
    res_bits_d = res_bits_q;
    valid_d    = valid_q;
    conn_d     = conn_q;
    pullup_d   = pullup_q;
    acc_d      = 1'b0;
    done_d     = 1'b0;
    status_d   = ST_NONE;
    pad_wr     = 1'b0;
    pad_byte   = rx_byte;

    unique case (phase_q)
      PH_IDLE: begin
        if (req_i == REQ_CONVERT || req_i == REQ_READ) begin
          job_d     = (req_i == REQ_CONVERT) ? KIND_CONV : KIND_FETCH;
          phase_d   = PH_BUS_IDLE;
          wait_d    = '0;
          pullup_d  = 1'b0;
          tx_idx_d  = '0;
          rx_idx_d  = '0;
          bit_pos_d = '0;
          shift_d   = '0;
          acc_d     = 1'b1;
        end
      end
      PH_BUS_IDLE: begin
        if (line_i) begin
          phase_d = PH_RESET_LOW;
          wait_d  = ResetLowUs;
        end else if (wait_inc > StuckLimitUs) begin
          conn_d   = 1'b0;
          valid_d  = 1'b0;
          phase_d  = PH_IDLE;
          job_d    = KIND_IDLE;
          wait_d   = '0;
          done_d   = 1'b1;
          status_d = ST_BUS_STUCK;
        end else begin
          wait_d = wait_inc;
        end
      end
      PH_RESET_LOW: begin
        wait_d = wait_dec;
        if (over) begin
          phase_d = PH_PRESENCE;
          wait_d  = {3'd0, cfg_i.presence_delay_us};
        end
      end
      PH_PRESENCE: begin
        wait_d = wait_dec;
        if (over) begin
          if (line_i) begin
            conn_d   = 1'b0;
            valid_d  = 1'b0;
            phase_d  = PH_IDLE;
            job_d    = KIND_IDLE;
            wait_d   = '0;
            done_d   = 1'b1;
            status_d = ST_NO_PRESENT;
          end else begin
            conn_d  = 1'b1;
            phase_d = PH_RECOVER;
            wait_d  = RecoverUs;
          end
        end
      end
      PH_RECOVER: begin
        wait_d = wait_dec;
        if (over) begin
          tx_idx_d  = '0;
          bit_pos_d = '0;
          shift_d   = tx_byte(4'd0, cfg_i.use_address, cfg_i.rom_address, job_q);
          phase_d   = PH_WR_LOW;
          wait_d    = low_time(shift_d[0], cfg_i);
        end
      end
      PH_WR_LOW: begin
        wait_d = wait_dec;
        if (over) begin
          if (last_bit && job_q == KIND_CONV && cfg_i.parasite_power) begin
            pullup_d = 1'b1;
          end
          wait_d    = shift_q[0] ? TailOneUs : TailZeroUs;
          shift_d   = shift_q >> 1;
          bit_pos_d = bit_pos_inc;
          if (bit_pos_inc == 3'd0) begin
            tx_idx_d = tx_idx_q + 4'd1;
          end
          phase_d = PH_WR_TAIL;
        end
      end
      PH_WR_TAIL: begin
        wait_d = wait_dec;
        if (over) begin
          if (tx_idx_q < tx_len) begin
            if (bit_pos_q == 3'd0) begin
              shift_d = tx_byte(tx_idx_q, cfg_i.use_address, cfg_i.rom_address, job_q);
            end
            phase_d = PH_WR_LOW;
            wait_d  = low_time(shift_d[0], cfg_i);
          end else if (job_q == KIND_FETCH) begin
            rx_idx_d  = '0;
            shift_d   = '0;
            bit_pos_d = '0;
            phase_d   = PH_RD_LOW;
            wait_d    = {3'd0, cfg_i.read_low_us};
          end else begin
            phase_d  = PH_IDLE;
            job_d    = KIND_IDLE;
            wait_d   = '0;
            done_d   = 1'b1;
            status_d = ST_CONVERT;
          end
        end
      end
      PH_RD_LOW: begin
        wait_d = wait_dec;
        if (over) begin
          phase_d = PH_RD_SAMPLE;
          wait_d  = {3'd0, cfg_i.read_sample_us};
        end
      end
      PH_RD_SAMPLE: begin
        wait_d = wait_dec;
        if (over) begin
          shift_d   = rx_byte;
          bit_pos_d = bit_pos_inc;
          if (bit_pos_inc == 3'd0) begin
            pad_wr   = ({1'b0, rx_idx_q} < 5'(ScratchBytes));
            shift_d  = '0;
            rx_idx_d = rx_idx_q + 4'd1;
          end
          phase_d = PH_RD_TAIL;
          wait_d  = ReadTailUs;
        end
      end
      PH_RD_TAIL: begin
        wait_d = wait_dec;
        if (over) begin
          if ({1'b0, rx_idx_q} >= 5'(ScratchBytes)) begin
            phase_d = PH_IDLE;
            job_d   = KIND_IDLE;
            wait_d  = '0;
            done_d  = 1'b1;
            if (same_q) begin
              valid_d  = 1'b0;
              status_d = ST_ALL_SAME;
            end else if (!crc_ok_q) begin
              valid_d  = 1'b0;
              status_d = ST_CRC_ERROR;
            end else begin
              res_bits_d = new_res;
              case (new_res)
                4'd9:    raw_d = raw_word & 16'hFFF8;
                4'd10:   raw_d = raw_word & 16'hFFFC;
                4'd11:   raw_d = raw_word & 16'hFFFE;
                default: raw_d = raw_word;
              endcase
              valid_d  = 1'b1;
              status_d = ST_READ_OK;
            end
          end else begin
            phase_d = PH_RD_LOW;
            wait_d  = {3'd0, cfg_i.read_low_us};
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        job_d   = KIND_IDLE;
        wait_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      job_q      <= KIND_IDLE;
      wait_q     <= '0;
      tx_idx_q   <= '0;
      rx_idx_q   <= '0;
      bit_pos_q  <= '0;
      shift_q    <= '0;
      raw_q      <= '0;
      res_bits_q <= 4'd12;
      valid_q    <= 1'b0;
      conn_q     <= 1'b0;
      pullup_q   <= 1'b0;
      acc_q      <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= ST_NONE;
    end else if (step_i) begin
      phase_q    <= phase_d;
      job_q      <= job_d;
      wait_q     <= wait_d;
      tx_idx_q   <= tx_idx_d;
      rx_idx_q   <= rx_idx_d;
      bit_pos_q  <= bit_pos_d;
      shift_q    <= shift_d;
      raw_q      <= raw_d;
      res_bits_q <= res_bits_d;
      valid_q    <= valid_d;
      conn_q     <= conn_d;
      pullup_q   <= pullup_d;
      acc_q      <= acc_d;
      done_q     <= done_d;
      status_q   <= status_d;
    end
  end

  // The first byte restarts the digest; the ninth byte is compared with the CRC instead of being folded into it.
  always_ff @(posedge clk_i) begin
    if (step_i && pad_wr) begin
      if (rx_idx_q == 4'd0) begin
        byte0_q <= pad_byte;
        same_q  <= 1'b1;
        crc_q   <= crc8_byte(8'd0, pad_byte);
      end else begin
        same_q <= same_q & (pad_byte == byte0_q);
        if (rx_idx_q < 4'(ScratchBytes - 1)) begin
          crc_q <= crc8_byte(crc_q, pad_byte);
        end else begin
          crc_ok_q <= (crc_q == pad_byte);
        end
      end
      if (rx_idx_q == 4'd1) begin
        byte1_q <= pad_byte;
      end
      if (rx_idx_q == 4'd4) begin
        byte4_q <= pad_byte;
      end
    end
  end

  assign res_o.drive_low          = (phase_q == PH_RESET_LOW) || (phase_q == PH_WR_LOW) ||
                                    (phase_q == PH_RD_LOW);
  assign res_o.strong_pullup      = pullup_q;
  assign res_o.busy               = (phase_q != PH_IDLE);
  assign res_o.accepted           = acc_q;
  assign res_o.done               = done_q;
  assign res_o.status             = status_q;
  assign res_o.raw_temp           = raw_q;
  assign res_o.temp_valid         = valid_q;
  assign res_o.resolution_bits    = res_bits_q;
  assign res_o.conversion_time_ms = conv_time(res_bits_q);
  assign res_o.connected          = conn_q;

endmodule
